// ===== hw/rtl/spadd_pkg.sv =====
`default_nettype none
package spadd_pkg;

	localparam int MAX_TERMS = 16;
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);
	localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int COEF_W    = 32;
	localparam int EXP_W     = 16;

	typedef enum logic [1:0] {
		OP_LOAD_FIRST  = 2'd0,
		OP_LOAD_SECOND = 2'd1,
		OP_RUN         = 2'd2,
		OP_NONE        = 2'd3
	} op_t;

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic [EXP_W-1:0]  expo;
	} term_t;

	// controller to datapath
	typedef struct packed {
		logic load_first;
		logic load_second;
		logic step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic step_last;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spadd_ctrl.sv =====
`default_nettype none
module spadd_ctrl
	import spadd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire stat_t       stat,
	output cmd_t             cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;
	op_t    op;

	assign op       = op_t'(operation);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.load_first  = accept && (op == OP_LOAD_FIRST);
		cmd.load_second = accept && (op == OP_LOAD_SECOND);
		cmd.step        = (state_q == ST_RUN) && stat.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_RUN)) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (stat.out_free && stat.step_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/spadd_dp.sv =====
`default_nettype none
module spadd_dp
	import spadd_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output stat_t                         stat,
	input  wire logic signed [COEF_W-1:0] term_coefficient,
	input  wire logic [EXP_W-1:0]         term_exponent,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [COEF_W-1:0]      sum_coefficient,
	output logic [EXP_W-1:0]              sum_exponent,
	output logic                          has_term,
	output logic                          last_term,
	output logic                          dropped_terms
);

	term_t             first_rf  [MAX_TERMS];
	term_t             second_rf [MAX_TERMS];
	logic [CNT_W-1:0]  first_cnt_q, second_cnt_q;
	logic [CNT_W-1:0]  a_q, b_q;
	logic              ovf_q;
	logic              out_valid_q;
	logic [COEF_W-1:0] coef_q;
	logic [EXP_W-1:0]  expo_q;
	logic              has_q, last_q, drop_q;

	term_t             p, q;
	logic              a_rem, b_rem, take_a, take_b;
	logic [CNT_W-1:0]  a_nx, b_nx;
	logic [COEF_W-1:0] coef_d;
	logic [EXP_W-1:0]  expo_d;
	logic              last_d;
	logic              first_full, second_full;

	assign first_full  = (first_cnt_q == CNT_W'(MAX_TERMS));
	assign second_full = (second_cnt_q == CNT_W'(MAX_TERMS));

	assign p     = first_rf[a_q[IDX_W-1:0]];
	assign q     = second_rf[b_q[IDX_W-1:0]];
	assign a_rem = (a_q < first_cnt_q);
	assign b_rem = (b_q < second_cnt_q);

	always_comb begin
		take_a = 1'b0;
		take_b = 1'b0;
		priority if (a_rem && b_rem) begin
			take_a = (p.expo >= q.expo);
			take_b = (p.expo <= q.expo);
		end else if (a_rem) begin
			take_a = 1'b1;
		end else if (b_rem) begin
			take_b = 1'b1;
		end
		a_nx   = a_q + CNT_W'(take_a);
		b_nx   = b_q + CNT_W'(take_b);
		last_d = !(a_nx < first_cnt_q) && !(b_nx < second_cnt_q);
		priority if (take_a && take_b) begin
			coef_d = p.coef + q.coef;
			expo_d = p.expo;
		end else if (take_a) begin
			coef_d = p.coef;
			expo_d = p.expo;
		end else if (take_b) begin
			coef_d = q.coef;
			expo_d = q.expo;
		end else begin
			coef_d = '0;
			expo_d = '0;
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.step_last = last_d;

	always_ff @(posedge clk) begin
		if (cmd.load_first && !first_full)
			first_rf[first_cnt_q[IDX_W-1:0]] <= '{coef: term_coefficient, expo: term_exponent};
		if (cmd.load_second && !second_full)
			second_rf[second_cnt_q[IDX_W-1:0]] <= '{coef: term_coefficient, expo: term_exponent};
		if (cmd.step) begin
			coef_q <= coef_d;
			expo_q <= expo_d;
			has_q  <= take_a || take_b;
			last_q <= last_d;
			drop_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			a_q          <= '0;
			b_q          <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_first) begin
				if (first_full) ovf_q <= 1'b1;
				else first_cnt_q <= first_cnt_q + CNT_W'(1);
			end
			if (cmd.load_second) begin
				if (second_full) ovf_q <= 1'b1;
				else second_cnt_q <= second_cnt_q + CNT_W'(1);
			end
			if (cmd.step) begin
				out_valid_q <= 1'b1;
				if (last_d) begin
					a_q          <= '0;
					b_q          <= '0;
					first_cnt_q  <= '0;
					second_cnt_q <= '0;
					ovf_q        <= 1'b0;
				end else begin
					a_q <= a_nx;
					b_q <= b_nx;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign sum_coefficient = signed'(coef_q);
	assign sum_exponent    = expo_q;
	assign has_term        = has_q;
	assign last_term       = last_q;
	assign dropped_terms   = drop_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sparse_polynomial_add_merge_top.sv =====
// Sparse polynomial adder: two-way merge of two term stores.
// Input channel (in_valid/in_ready) carries one item per handshake:
// operation 0 or 1 loads a term (coefficient, exponent) into the first or
// second store, operation 2 runs the merge, operation 3 is ignored.
// A load gives no result; terms beyond MAX_TERMS per
// store are dropped and flagged on the next run's results.
// A run emits one term per cycle while the receiver does not stall,
// through a single output register (out_valid/out_ready): highest
// exponent first, equal exponents summed modulo 2^32. The first result
// is registered once the controller is in its run state and the output
// register is free. With both stores empty a single result with has_term
// low is given. last_term marks the final result, after which both
// stores and the drop flag are empty. in_ready is low during a run.
// When the receiver stalls, the output register holds its item and the
// walk pauses; loads are still accepted while a finished result waits.
// Reset empties both stores, clears the drop flag and the output valid.
`default_nettype none
module sparse_polynomial_add_merge_top
	import spadd_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               operation,
	input  wire logic signed [COEF_W-1:0] term_coefficient,
	input  wire logic [EXP_W-1:0]         term_exponent,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [COEF_W-1:0]      sum_coefficient,
	output logic [EXP_W-1:0]              sum_exponent,
	output logic                          has_term,
	output logic                          last_term,
	output logic                          dropped_terms
);

	cmd_t  cmd;
	stat_t stat;

	spadd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd)
	);

	spadd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.term_coefficient (term_coefficient),
		.term_exponent    (term_exponent),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sum_coefficient  (sum_coefficient),
		.sum_exponent     (sum_exponent),
		.has_term         (has_term),
		.last_term        (last_term),
		.dropped_terms    (dropped_terms)
	);

endmodule
`default_nettype wire
